>>> rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NRM = 3'd4
    } t_op;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;
endpackage

>>> rtl/rational_arithmetic_unit.sv
// rational arithmetic unit; zero and error items skip the back end's gcd and divisions
// throughput set by the back end, which stalls on m_axis_tready: one item per bit-serial gcd
// plus two restoring divisions, with at most one item in the front, two in the queue and one
// in the back
// synchronous active-low reset clears all handshake and sequencer state
// depends on rau_pkg, rau_front, rau_queue, rau_back
module rational_arithmetic_unit #(
    parameter int OPERAND_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode, a_num, a_den, b_num, b_den
    input  logic [((4*OPERAND_BITS+1)+7)/8*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_num, res_den
    output logic [63:0] m_axis_tdata,
    // error
    output logic        m_axis_tuser
);
    import rau_pkg::*;
    localparam int OPB = OPERAND_BITS;
    localparam int MW = 2 * OPB + 1;
    localparam int QW = 2 * MW + 3;
    logic f_valid, f_ready, f_neg, f_err, f_zero;
    logic [MW-1:0] f_mn, f_md;
    logic q_valid, q_ready;
    logic [QW-1:0] q_data;
    logic [RES_NUM_W-1:0] w_num;
    logic [RES_DEN_W-1:0] w_den;

    rau_front #(.OPB(OPB), .MW(MW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[2:0]),
        .i_a_num(s_axis_tdata[3 +: OPB]),
        .i_a_den(s_axis_tdata[3+OPB +: OPB-1]),
        .i_b_num(s_axis_tdata[2+2*OPB +: OPB]),
        .i_b_den(s_axis_tdata[2+3*OPB +: OPB-1]),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_mn(f_mn), .o_md(f_md), .o_neg(f_neg), .o_err(f_err), .o_zero(f_zero)
    );

    rau_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready),
        .i_data({f_zero, f_err, f_neg, f_md, f_mn}),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    rau_back #(.MW(MW)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready),
        .i_mn(q_data[MW-1:0]), .i_md(q_data[2*MW-1:MW]),
        .i_neg(q_data[2*MW]), .i_err(q_data[2*MW+1]), .i_zero(q_data[2*MW+2]),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_num(w_num), .o_den(w_den), .o_err(m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, w_den, w_num};
endmodule

>>> rtl/rau_front.sv
// front end: checks operands, cross-multiplies, forms sign and magnitudes
// depends on rau_pkg
module rau_front #(
    parameter int OPB = 16,
    parameter int MW = 2 * OPB + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_op,
    input  logic [OPB-1:0]    i_a_num,
    input  logic [OPB-2:0]    i_a_den,
    input  logic [OPB-1:0]    i_b_num,
    input  logic [OPB-2:0]    i_b_den,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MW-1:0]     o_mn,
    output logic [MW-1:0]     o_md,
    output logic              o_neg,
    output logic              o_err,
    output logic              o_zero
);
    import rau_pkg::*;
    logic r_busy, r_vld;
    logic [2:0] r_op;
    logic signed [OPB-1:0] r_an, r_bn;
    logic [OPB-2:0] r_ad, r_bd;
    logic [1:0] r_ph;
    logic signed [MW:0] r_p1, r_p2, r_acc;
    logic [MW-1:0] r_d;
    logic r_err;
    logic signed [OPB-1:0] w_x;
    logic signed [OPB:0] w_y;
    logic signed [2*OPB+1:0] w_prod;
    logic signed [MW:0] w_n;
    logic [MW-1:0] w_dm;

    always_comb begin
        w_x = r_an;
        w_y = {2'b00, r_bd};
        case (r_ph)
            2'd0: begin
                w_x = r_an;
                w_y = (r_op == OP_MUL) ? {r_bn[OPB-1], r_bn} : {2'b00, r_bd};
            end
            2'd1: begin
                w_x = r_bn;
                w_y = {2'b00, r_ad};
            end
            2'd2: begin
                w_x = $signed({1'b0, r_ad});
                w_y = (r_op == OP_DIV) ? {r_bn[OPB-1], r_bn} : {2'b00, r_bd};
            end
            default: begin
                w_x = r_an;
                w_y = {2'b00, r_bd};
            end
        endcase
        w_prod = w_x * w_y;
    end

    always_comb begin
        case (r_op)
            OP_ADD:  w_n = r_p1 + r_p2;
            OP_SUB:  w_n = r_p1 - r_p2;
            OP_NRM:  w_n = (MW+1)'(r_an);
            default: w_n = r_p1;
        endcase
    end

    assign w_dm = (r_op == OP_NRM) ? MW'(r_ad) : r_d;
    assign o_ready = !r_busy;
    assign o_valid = r_vld;
    assign o_mn = r_acc[MW] ? MW'(-r_acc) : r_acc[MW-1:0];
    assign o_md = r_d;
    assign o_neg = r_acc[MW];
    assign o_err = r_err;
    assign o_zero = (r_acc == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld <= 1'b0;
            r_ph <= 2'd0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy <= 1'b1;
                r_ph <= 2'd0;
                r_op <= i_op;
                r_an <= i_a_num;
                r_ad <= i_a_den;
                r_bn <= i_b_num;
                r_bd <= i_b_den;
            end
        end else if (r_vld) begin
            if (i_ready) begin
                r_vld <= 1'b0;
                r_busy <= 1'b0;
            end
        end else begin
            case (r_ph)
                2'd0: begin
                    r_p1 <= (MW+1)'(w_prod);
                    r_ph <= 2'd1;
                end
                2'd1: begin
                    r_p2 <= (MW+1)'(w_prod);
                    r_ph <= 2'd2;
                end
                2'd2: begin
                    r_d <= (r_op == OP_DIV && r_bn[OPB-1]) ? MW'(-w_prod) : MW'(w_prod);
                    if (r_op == OP_DIV && r_bn[OPB-1])
                        r_p1 <= -r_p1;
                    r_ph <= 2'd3;
                end
                default: begin
                    r_acc <= w_n;
                    r_d <= w_dm;
                    r_err <= (r_op > OP_NRM) || (r_ad == '0)
                        || (r_op != OP_NRM && r_bd == '0)
                        || (r_op == OP_DIV && r_bn == '0);
                    r_vld <= 1'b1;
                end
            endcase
        end
    end
endmodule

>>> rtl/rau_queue.sv
// two-entry queue between front and back
// depends on nothing
module rau_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr)
            r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr)
                r_wp <= !r_wp;
            if (w_rd)
                r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule

>>> rtl/rau_back.sv
// back end: binary gcd, two restoring divisions, output register
// depends on rau_pkg
module rau_back #(
    parameter int MW = 33
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [MW-1:0]                 i_mn,
    input  logic [MW-1:0]                 i_md,
    input  logic                          i_neg,
    input  logic                          i_err,
    input  logic                          i_zero,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rau_pkg::RES_NUM_W-1:0] o_num,
    output logic [rau_pkg::RES_DEN_W-1:0] o_den,
    output logic                          o_err
);
    import rau_pkg::*;
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIVN = 5'b00100,
        S_DIVD = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;
    localparam int CW = $clog2(MW + 1);
    t_state r_st;
    logic [MW-1:0] r_u, r_v, r_g, r_mn, r_md, r_q, r_rem, r_dvd, r_qn;
    logic [CW-1:0] r_k, r_i;
    logic r_neg;
    logic [MW:0] w_trial;
    logic [MW-1:0] w_rsh;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign w_rsh = {r_rem[MW-2:0], r_dvd[MW-1]};
    assign w_trial = {1'b0, w_rsh} - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_neg <= i_neg;
                        r_mn <= i_mn;
                        r_md <= i_md;
                        r_u <= i_mn;
                        r_v <= i_md;
                        r_k <= '0;
                        if (i_err || i_zero) begin
                            o_num <= '0;
                            o_den <= RES_DEN_W'(1);
                            o_err <= i_err;
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    if (r_u == r_v) begin
                        r_g <= r_u << r_k;
                        r_dvd <= r_mn;
                        r_rem <= '0;
                        r_q <= '0;
                        r_i <= '0;
                        r_st <= S_DIVN;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + CW'(1);
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u > r_v) begin
                        r_u <= (r_u - r_v) >> 1;
                    end else begin
                        r_v <= (r_v - r_u) >> 1;
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (r_i == CW'(MW - 1)) begin
                        r_i <= '0;
                        if (r_st == S_DIVN) begin
                            r_qn <= {r_q[MW-2:0], !w_trial[MW]};
                            r_dvd <= r_md;
                            r_rem <= '0;
                            r_q <= '0;
                            r_st <= S_DIVD;
                        end else begin
                            o_num <= r_neg ? RES_NUM_W'(-r_qn) : RES_NUM_W'(r_qn);
                            o_den <= RES_DEN_W'({r_q[MW-2:0], !w_trial[MW]});
                            o_err <= 1'b0;
                            r_st <= S_OUT;
                        end
                    end else begin
                        r_dvd <= r_dvd << 1;
                        if (!w_trial[MW]) begin
                            r_rem <= w_trial[MW-1:0];
                            r_q <= {r_q[MW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_q <= {r_q[MW-2:0], 1'b0};
                        end
                        r_i <= r_i + CW'(1);
                    end
                end
                S_OUT: begin
                    if (i_ready)
                        r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
